// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared helpers for concurrent assertions, clocked and reset-gated.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) else $error(msg);

// Condition must never hold at a clock edge outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) else $error(msg);

// Antecedent at one edge implies consequent at the next edge
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/mwo_pkg.sv =====
// ----------------------------------------------------------------------------
// mwo_pkg
// Types and constants shared by the multi-waveform oscillator modules.
// ----------------------------------------------------------------------------
package mwo_pkg;

  // Payload widths
  localparam int StepW   = 32;
  localparam int AmpW    = 16;
  localparam int SampleW = 16;
  localparam int FracW   = 16;  // top accumulator bits used for wave shaping

  // Configuration port
  localparam int CfgIdxW  = 4;
  localparam int CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] RegWaveformSelect = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegNoiseSeed      = CfgIdxW'(1);

  // Noise generator: Galois LFSR, right shift
  localparam logic [15:0] LfsrTaps = 16'hB400;

  // Queue between front and back
  localparam int QueueDepth = 4;
  localparam int QPtrW      = $clog2(QueueDepth);

  typedef enum logic [2:0] {
    WAVE_SINE     = 3'd0,
    WAVE_SAW      = 3'd1,
    WAVE_SQUARE   = 3'd2,
    WAVE_TRIANGLE = 3'd3,
    WAVE_NOISE    = 3'd4
  } wave_e;

  // One configuration write transfer
  typedef struct packed {
    logic                valid;
    logic [CfgIdxW-1:0]  index;
    logic [CfgDataW-1:0] data;
  } mwo_cfg_wr_t;

  // Classified tick handed from front to back
  typedef struct packed {
    logic [2:0]       sel;      // waveform code, may be an unused code
    logic [FracW-1:0] frac;     // top bits of the new phase
    logic             le_half;  // new phase <= half cycle
    logic [15:0]      noise;    // noise value held for this tick
    logic [AmpW-1:0]  amp;
  } mwo_item_t;

endpackage

// ===== rtl/mwo_fifo.sv =====
// ----------------------------------------------------------------------------
// mwo_fifo
// Small flop-based queue that decouples the phase front from the wave back.
// ----------------------------------------------------------------------------
module mwo_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  mwo_pkg::mwo_item_t push_data_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               empty_o,
  output mwo_pkg::mwo_item_t head_o
);
  import mwo_pkg::*;

  `include "assert_macros.svh"

  mwo_item_t        mem_q [QueueDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QPtrW:0]   count_q;

  assign full_o  = (count_q == (QPtrW+1)'(QueueDepth));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_i)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (push_i && !pop_i)      count_q <= count_q + 1'b1;
      else if (!push_i && pop_i) count_q <= count_q - 1'b1;
    end
  end

  // Storage, no reset
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_data_i;
  end

  `ASSERT_NEVER(a_fifo_overflow, clk_i, rst_ni, push_i && full_o, "push into full queue")
  `ASSERT_NEVER(a_fifo_underflow, clk_i, rst_ni, pop_i && empty_o, "pop from empty queue")

endmodule

// ===== rtl/mwo_front.sv =====
// ----------------------------------------------------------------------------
// mwo_front
// Takes ticks, advances the phase accumulator and noise LFSR, holds the
// configuration, and queues one classified item per tick.
// ----------------------------------------------------------------------------
module mwo_front #(
  parameter int PHASE_BITS = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  input  logic signed [mwo_pkg::StepW-1:0] phase_step_i,
  input  logic [mwo_pkg::AmpW-1:0]         amplitude_i,
  input  mwo_pkg::mwo_cfg_wr_t             cfg_wr_i,
  input  logic                             q_full_i,
  output logic                             push_o,
  output mwo_pkg::mwo_item_t               item_o
);
  import mwo_pkg::*;

  `include "assert_macros.svh"

  localparam int SumW = ((PHASE_BITS > StepW) ? PHASE_BITS : StepW) + 2;

  logic [PHASE_BITS-1:0] acc_q, acc_d;
  logic [2:0]            sel_q;
  logic [15:0]           lfsr_q, lfsr_d;
  logic [15:0]           noise_q, noise_d;
  logic [15:0]           lfsr_step;

  logic            accept;
  logic            seed_wr, sel_wr;
  logic [SumW-1:0] sum;
  logic            wrapped;
  logic            le_half;

  assign accept  = in_valid_i && !q_full_i;
  assign sel_wr  = cfg_wr_i.valid && (cfg_wr_i.index == RegWaveformSelect);
  assign seed_wr = cfg_wr_i.valid && (cfg_wr_i.index == RegNoiseSeed);

  // Phase update: wrap is any bit above the accumulator, or a negative sum
  assign sum = {{(SumW-PHASE_BITS){1'b0}}, acc_q}
             + {{(SumW-StepW){phase_step_i[StepW-1]}}, phase_step_i};
  assign wrapped = |sum[SumW-1:PHASE_BITS];
  assign acc_d   = accept ? sum[PHASE_BITS-1:0] : acc_q;
  assign le_half = !acc_d[PHASE_BITS-1] || (acc_d[PHASE_BITS-2:0] == '0);

  // One LFSR step
  assign lfsr_step = (lfsr_q >> 1) ^ (lfsr_q[0] ? LfsrTaps : 16'h0000);

  // Noise state: seed load, or one step on a wrapping noise tick
  always_comb begin
    lfsr_d  = lfsr_q;
    noise_d = noise_q;
    if (seed_wr) begin
      lfsr_d = (cfg_wr_i.data == '0) ? 16'h0001 : cfg_wr_i.data[15:0];
    end else if (accept && (sel_q == WAVE_NOISE) && wrapped) begin
      lfsr_d  = lfsr_step;
      noise_d = lfsr_step ^ 16'h8000;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q   <= '0;
      sel_q   <= WAVE_SINE;
      lfsr_q  <= 16'h0001;
      noise_q <= '0;
    end else begin
      acc_q   <= acc_d;
      lfsr_q  <= lfsr_d;
      noise_q <= noise_d;
      if (sel_wr) sel_q <= cfg_wr_i.data[2:0];
    end
  end

  // Queue entry
  assign push_o         = accept;
  assign item_o.sel     = sel_q;
  assign item_o.frac    = acc_d[PHASE_BITS-1 -: FracW];
  assign item_o.le_half = le_half;
  assign item_o.noise   = noise_d;
  assign item_o.amp     = amplitude_i;

  `ASSERT_ALWAYS(a_lfsr_nonzero, clk_i, rst_ni, lfsr_q != '0, "noise LFSR locked at zero")
  `ASSERT_NEXT(a_lfsr_quiet, clk_i, rst_ni, accept && (sel_q != WAVE_NOISE) && !seed_wr, $stable(lfsr_q) && $stable(noise_q), "noise state moved outside noise mode")

endmodule

// ===== rtl/mwo_back.sv =====
// ----------------------------------------------------------------------------
// mwo_back
// Three-stage wave pipeline: shape the wave, apply gain, then truncate and
// saturate into the output register.
// ----------------------------------------------------------------------------
module mwo_back #(
  parameter int SINE_TABLE_DEPTH = 256
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               q_empty_i,
  input  mwo_pkg::mwo_item_t                 head_i,
  output logic                               pop_o,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [mwo_pkg::SampleW-1:0] sample_o,
  output logic                               clipped_o
);
  import mwo_pkg::*;

  `include "assert_macros.svh"

  localparam int IdxW  = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int IdxPW = 14 + IdxW;
  localparam int ProdW = SampleW + AmpW + 1;

  localparam longint OneQ30 = 64'sd1073741824;

  logic [14:0] sine_rom [SINE_TABLE_DEPTH+1];

  // Quarter-wave entry, Q30 Taylor series, evaluated at elaboration
  for (genvar g = 0; g <= SINE_TABLE_DEPTH; g++) begin : g_rom
    localparam longint unsigned X  = (64'd3373259426 * 64'(g)) / (64'd2 * SINE_TABLE_DEPTH);
    localparam longint unsigned X2 = (X * X) >> 30;
    localparam longint unsigned T1 = ((X  * X2) >> 30) / 64'd6;
    localparam longint unsigned T2 = ((T1 * X2) >> 30) / 64'd20;
    localparam longint unsigned T3 = ((T2 * X2) >> 30) / 64'd42;
    localparam longint unsigned T4 = ((T3 * X2) >> 30) / 64'd72;
    localparam longint unsigned T5 = ((T4 * X2) >> 30) / 64'd110;
    localparam longint unsigned T6 = ((T5 * X2) >> 30) / 64'd156;
    localparam longint Sum = longint'(X) - longint'(T1) + longint'(T2) - longint'(T3)
                           + longint'(T4) - longint'(T5) + longint'(T6);
    localparam longint Clamped = (Sum < 0) ? 64'sd0 : ((Sum > OneQ30) ? OneQ30 : Sum);
    localparam longint Rounded = (Clamped * 32767 + 64'sd536870912) >>> 30;
    localparam longint Entry   = (Rounded > 32767) ? 64'sd32767 : Rounded;
    assign sine_rom[g] = 15'(Entry);
  end

  // Pipeline registers
  logic                      v1_q, v2_q, out_valid_q;
  logic signed [SampleW-1:0] wave1_q;
  logic [AmpW-1:0]           amp1_q;
  logic signed [ProdW-1:0]   prod2_q;
  logic signed [SampleW-1:0] sample_q;
  logic                      clip_q;

  logic ready1, ready2, ready3;

  // Backpressure chain
  assign ready3 = !out_valid_q || !out_stall_i;
  assign ready2 = !v2_q || ready3;
  assign ready1 = !v1_q || ready2;
  assign pop_o  = !q_empty_i && ready1;

  // Stage 1: wave shaping
  logic [IdxPW-1:0]          idx_prod;
  logic [IdxW-1:0]           idx, idx_mir, rom_addr;
  logic [14:0]               rom_val;
  logic signed [SampleW-1:0] sine_w, wave;
  logic signed [18:0]        tri_raw;

  assign idx_prod = IdxPW'(head_i.frac[13:0]) * IdxPW'(SINE_TABLE_DEPTH);
  assign idx      = idx_prod[14 +: IdxW];
  assign idx_mir  = IdxW'(SINE_TABLE_DEPTH) - idx;
  assign rom_addr = head_i.frac[14] ? idx_mir : idx;
  assign rom_val  = sine_rom[rom_addr];
  assign sine_w   = head_i.frac[15] ? -$signed({1'b0, rom_val}) : $signed({1'b0, rom_val});

  assign tri_raw = head_i.le_half
                 ? $signed({2'b00, head_i.frac, 1'b0}) - 19'sd32768
                 : 19'sd98304 - $signed({2'b00, head_i.frac, 1'b0});

  always_comb begin
    case (head_i.sel)
      WAVE_SINE:   wave = sine_w;
      WAVE_SAW:    wave = $signed({~head_i.frac[15], head_i.frac[14:0]});
      WAVE_SQUARE: wave = head_i.le_half ? 16'sh8000 : 16'sh7FFF;
      WAVE_TRIANGLE: begin
        if (tri_raw > 19'sd32767)       wave = 16'sh7FFF;
        else if (tri_raw < -19'sd32768) wave = 16'sh8000;
        else                            wave = tri_raw[15:0];
      end
      WAVE_NOISE:  wave = $signed(head_i.noise);
      default:     wave = '0;
    endcase
  end

  // Stage 3: truncate toward zero, then saturate
  logic signed [ProdW-1:0] biased;
  logic signed [18:0]      scaled;
  logic signed [SampleW-1:0] sat_val;
  logic                      sat_hit;

  assign biased = prod2_q + (prod2_q[ProdW-1] ? ProdW'(14'h3FFF) : ProdW'(0));
  assign scaled = biased[ProdW-1:14];

  always_comb begin
    sat_hit = 1'b0;
    sat_val = scaled[15:0];
    if (scaled > 19'sd32767) begin
      sat_val = 16'sh7FFF;
      sat_hit = 1'b1;
    end else if (scaled < -19'sd32768) begin
      sat_val = 16'sh8000;
      sat_hit = 1'b1;
    end
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (ready1) v1_q        <= !q_empty_i;
      if (ready2) v2_q        <= v1_q;
      if (ready3) out_valid_q <= v2_q;
    end
  end

  // Data path, no reset
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      wave1_q <= wave;
      amp1_q  <= head_i.amp;
    end
    if (ready2 && v1_q) begin
      prod2_q <= wave1_q * $signed({1'b0, amp1_q});
    end
    if (ready3 && v2_q) begin
      sample_q <= sat_val;
      clip_q   <= sat_hit;
    end
  end

  assign out_valid_o = out_valid_q;
  assign sample_o    = sample_q;
  assign clipped_o   = clip_q;

  `ASSERT_NEXT(a_pop_loads, clk_i, rst_ni, pop_o, v1_q, "popped item not captured")
  `ASSERT_NEXT(a_gain_holds, clk_i, rst_ni, v2_q && !ready3, v2_q && $stable(prod2_q), "gain stage lost data under stall")

endmodule

// ===== rtl/multi_waveform_oscillator.sv =====
// ----------------------------------------------------------------------------
// multi_waveform_oscillator
// Numerically controlled oscillator with sine, saw, square, triangle and
// noise waves, gain and saturation.
// ----------------------------------------------------------------------------
//  channel  | signals                                 | direction
//  ---------+-----------------------------------------+-----------
//  in       | in_valid_i, in_stall_o, phase_step_i,   | into block
//           | amplitude_i                             |
//  out      | out_valid_o, out_stall_i, sample_o,     | out of block
//           | clipped_o                               |
//  cfg      | cfg_valid_i, cfg_ready_o, cfg_index_i,  | into block
//           | cfg_data_i                              |
//
//  One tick is taken every cycle while in_stall_o is low; its sample passes
//  through the queue write at the accepting edge, then the wave shaping, gain
//  multiply and saturation registers. The phase add is combinational.
//  Reset clears the phase, noise state and selector; the LFSR resets to one.
//  in_stall_o rises only when the four-entry queue is full; out_stall_i
//  holds the back pipeline while the front keeps filling the queue.
//  cfg_ready_o is always high.
// ----------------------------------------------------------------------------
module multi_waveform_oscillator #(
  parameter int SINE_TABLE_DEPTH = 256,
  parameter int PHASE_BITS       = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // tick input
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [mwo_pkg::StepW-1:0]    phase_step_i,
  input  logic [mwo_pkg::AmpW-1:0]            amplitude_i,
  // sample output
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [mwo_pkg::SampleW-1:0]  sample_o,
  output logic                                clipped_o,
  // register writes
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [mwo_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  logic [mwo_pkg::CfgDataW-1:0]        cfg_data_i
);
  import mwo_pkg::*;

  mwo_cfg_wr_t cfg_wr;
  mwo_item_t   push_item, head_item;
  logic        push, pop, q_full, q_empty;

  // Register write transfer
  assign cfg_ready_o  = 1'b1;
  assign cfg_wr.valid = cfg_valid_i;
  assign cfg_wr.index = cfg_index_i;
  assign cfg_wr.data  = cfg_data_i;

  assign in_stall_o = q_full;

  mwo_front #(
    .PHASE_BITS (PHASE_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .phase_step_i (phase_step_i),
    .amplitude_i  (amplitude_i),
    .cfg_wr_i     (cfg_wr),
    .q_full_i     (q_full),
    .push_o       (push),
    .item_o       (push_item)
  );

  mwo_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_item),
    .full_o      (q_full),
    .pop_i       (pop),
    .empty_o     (q_empty),
    .head_o      (head_item)
  );

  mwo_back #(
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .head_i      (head_item),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sample_o    (sample_o),
    .clipped_o   (clipped_o)
  );

endmodule
